@@ rtl/lobm_pkg.sv @@
// ---------------------------------------------------------------------------
// lobm_pkg: shared definitions for the order book matcher
// Slot record layout, request and status codes, sequencer states.
// ---------------------------------------------------------------------------
package lobm_pkg;

  localparam int ORDER_SLOTS = 32;
  localparam int SLOT_IW     = $clog2(ORDER_SLOTS);
  localparam int SLOT_CW     = SLOT_IW + 1;

  localparam logic [1:0] KIND_NEW    = 2'd0;
  localparam logic [1:0] KIND_CANCEL = 2'd1;
  localparam logic [1:0] KIND_MODIFY = 2'd2;

  localparam logic [1:0] TYP_LIMIT  = 2'd0;
  localparam logic [1:0] TYP_MARKET = 2'd1;
  localparam logic [1:0] TYP_IOC    = 2'd2;

  localparam logic [1:0] ST_DONE      = 2'd0;
  localparam logic [1:0] ST_DUPLICATE = 2'd1;
  localparam logic [1:0] ST_NOT_FOUND = 2'd2;
  localparam logic [1:0] ST_BOOK_FULL = 2'd3;

  localparam logic RK_FILL   = 1'b0;
  localparam logic RK_STATUS = 1'b1;

  localparam logic SIDE_BUY = 1'b0;

  typedef struct packed {
    logic [31:0] order_id;
    logic        side;
    logic [31:0] price;
    logic [31:0] remaining;
    logic [31:0] symbol;
    logic [31:0] arrival;
  } slot_t;

  localparam int SLOT_W = $bits(slot_t);

  typedef enum logic [2:0] {
    S_IDLE,
    S_FIND,
    S_ACT,
    S_SCAN,
    S_DECIDE,
    S_FILL,
    S_FREE,
    S_STATUS
  } state_t;

endpackage

@@ rtl/lobm_ram.sv @@
// ---------------------------------------------------------------------------
// lobm_ram: generic single-write, single-read RAM
// One write port, one read port with registered read data.
// ---------------------------------------------------------------------------
module lobm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/limit_order_book_matcher.sv @@
// ---------------------------------------------------------------------------
// limit_order_book_matcher: price-time priority matcher over one order book
// Sequencer walks a slot RAM one entry per cycle for lookup, best-price
// search and free-slot search; fills and a final status go out on strobes.
// ---------------------------------------------------------------------------
// A request is taken when start is high and busy is low; busy then stays high
// until the run ends. Each result appears for exactly one cycle with
// result_valid high and must be captured then, since there is no back-pressure.
// A run gives zero or more fill results (result_kind 0) and ends with one
// status result (result_kind 1, last 1); busy drops in that same cycle, so a
// new request may be issued right away. A new order runs an id lookup, a
// best-price search before each fill and, for a resting remainder, a
// free-slot search, one RAM read per cycle; a cancel runs only the id lookup.
// The slot RAM is not cleared: per-slot valid flops are reset instead.
module limit_order_book_matcher
  import lobm_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [1:0]  kind,
  input  logic [31:0] order_id,
  input  logic        side,
  input  logic [1:0]  order_type,
  input  logic [31:0] price,
  input  logic [31:0] quantity,
  input  logic [31:0] sequence_req,
  input  logic [31:0] symbol,
  output logic        busy,
  output logic        result_valid,
  output logic        result_kind,
  output logic [31:0] buy_order_id,
  output logic [31:0] sell_order_id,
  output logic [31:0] fill_price,
  output logic [31:0] fill_quantity,
  output logic [31:0] timestamp,
  output logic [31:0] fill_symbol,
  output logic [1:0]  status,
  output logic        last
);

  state_t state, state_next;

  // latched request
  logic [1:0]  r_kind;
  logic [31:0] r_id;
  logic        r_side;
  logic [1:0]  r_typ;
  logic [31:0] r_price;
  logic [31:0] r_rem;
  logic [31:0] r_ts;
  logic [31:0] r_sym;

  logic [1:0]  st_code, st_next;

  // sweep counter and read pipeline
  logic [SLOT_CW-1:0] idx;
  logic               pv;
  logic [SLOT_IW-1:0] pidx;

  logic [ORDER_SLOTS-1:0] valid;
  logic [31:0]            arrival_counter;

  logic        found;
  logic        found_side;
  logic [31:0] found_sym;
  logic [SLOT_IW-1:0] found_idx;

  logic               have_best;
  slot_t              best;
  logic [SLOT_IW-1:0] best_idx;
  logic [31:0]        best_age;

  // RAM ports
  logic               ram_we;
  logic [SLOT_IW-1:0] ram_waddr;
  slot_t              ram_wentry;
  logic [SLOT_W-1:0]  ram_rdata;
  slot_t              rd_entry;

  // sequencer flags
  logic sweep_begin;
  logic clr_found;
  logic take_found;
  logic fill_do;
  logic rest_do;
  logic emit_status;

  logic        issue;
  logic        cur_valid;
  logic        id_match;
  logic        scan_last;
  logic        cand;
  logic        better;
  logic [31:0] age;
  logic        respect;
  logic        crosses;
  logic        rests;
  logic [31:0] q;
  logic [31:0] rem_after;
  logic        free_cur;

  lobm_ram #(
    .WIDTH (SLOT_W),
    .DEPTH (ORDER_SLOTS)
  ) u_slots (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wentry),
    .raddr (idx[SLOT_IW-1:0]),
    .rdata (ram_rdata)
  );

  assign rd_entry  = slot_t'(ram_rdata);
  assign busy      = (state != S_IDLE);
  assign issue     = (idx < SLOT_CW'(ORDER_SLOTS));
  assign cur_valid = valid[pidx];
  assign id_match  = pv && cur_valid && (rd_entry.order_id == r_id);
  assign scan_last = pv && (pidx == SLOT_IW'(ORDER_SLOTS - 1));
  assign cand      = pv && cur_valid && (rd_entry.side != r_side);

  // age: larger is older; the counter wraps
  assign age = arrival_counter - rd_entry.arrival;

  always_comb begin
    if (!have_best) begin
      better = 1'b1;
    end else if (rd_entry.price != best.price) begin
      better = (r_side == SIDE_BUY) ? (rd_entry.price < best.price)
                                    : (rd_entry.price > best.price);
    end else begin
      better = (age > best_age);
    end
  end

  assign respect   = (r_typ != TYP_MARKET);
  assign crosses   = (r_side == SIDE_BUY) ? (best.price <= r_price) : (best.price >= r_price);
  assign rests     = (r_rem != 32'd0) && (r_typ != TYP_MARKET) && (r_typ != TYP_IOC);
  assign q         = (r_rem < best.remaining) ? r_rem : best.remaining;
  assign rem_after = r_rem - q;
  assign free_cur  = issue && !valid[idx[SLOT_IW-1:0]];

  // RAM write: fill write-back or a new resting order
  always_comb begin
    ram_we     = 1'b0;
    ram_waddr  = best_idx;
    ram_wentry = best;
    if (fill_do) begin
      ram_we               = 1'b1;
      ram_wentry.remaining = best.remaining - q;
    end else if (rest_do) begin
      ram_we               = 1'b1;
      ram_waddr            = idx[SLOT_IW-1:0];
      ram_wentry.order_id  = r_id;
      ram_wentry.side      = r_side;
      ram_wentry.price     = r_price;
      ram_wentry.remaining = r_rem;
      ram_wentry.symbol    = r_sym;
      ram_wentry.arrival   = arrival_counter;
    end
  end

  // next state and control
  always_comb begin
    state_next  = state;
    st_next     = st_code;
    sweep_begin = 1'b0;
    clr_found   = 1'b0;
    take_found  = 1'b0;
    fill_do     = 1'b0;
    rest_do     = 1'b0;
    emit_status = 1'b0;
    case (state)
      S_IDLE: begin
        if (start) begin
          sweep_begin = 1'b1;
          if (kind inside {KIND_NEW, KIND_CANCEL, KIND_MODIFY}) begin
            state_next = S_FIND;
          end else begin
            st_next    = ST_NOT_FOUND;
            state_next = S_STATUS;
          end
        end
      end
      S_FIND: begin
        if (id_match || scan_last) begin
          state_next = S_ACT;
        end
      end
      S_ACT: begin
        case (r_kind)
          KIND_NEW: begin
            if (found) begin
              st_next    = ST_DUPLICATE;
              state_next = S_STATUS;
            end else if (r_rem == 32'd0) begin
              st_next    = ST_DONE;
              state_next = S_STATUS;
            end else begin
              sweep_begin = 1'b1;
              state_next  = S_SCAN;
            end
          end
          KIND_CANCEL: begin
            clr_found  = found;
            st_next    = found ? ST_DONE : ST_NOT_FOUND;
            state_next = S_STATUS;
          end
          default: begin
            if (!found) begin
              st_next    = ST_NOT_FOUND;
              state_next = S_STATUS;
            end else begin
              clr_found  = 1'b1;
              take_found = 1'b1;
              if (r_rem == 32'd0) begin
                st_next    = ST_DONE;
                state_next = S_STATUS;
              end else begin
                sweep_begin = 1'b1;
                state_next  = S_SCAN;
              end
            end
          end
        endcase
      end
      S_SCAN: begin
        if (scan_last) begin
          state_next = S_DECIDE;
        end
      end
      S_DECIDE: begin
        if (!have_best || (respect && !crosses)) begin
          if (rests) begin
            sweep_begin = 1'b1;
            state_next  = S_FREE;
          end else begin
            st_next    = ST_DONE;
            state_next = S_STATUS;
          end
        end else begin
          state_next = S_FILL;
        end
      end
      S_FILL: begin
        fill_do = 1'b1;
        if (rem_after == 32'd0) begin
          st_next    = ST_DONE;
          state_next = S_STATUS;
        end else begin
          sweep_begin = 1'b1;
          state_next  = S_SCAN;
        end
      end
      S_FREE: begin
        if (!issue) begin
          st_next    = ST_BOOK_FULL;
          state_next = S_STATUS;
        end else if (free_cur) begin
          rest_do    = 1'b1;
          st_next    = ST_DONE;
          state_next = S_STATUS;
        end
      end
      S_STATUS: begin
        emit_status = 1'b1;
        state_next  = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      valid           <= '0;
      arrival_counter <= 32'd0;
      pv              <= 1'b0;
      have_best       <= 1'b0;
      result_valid    <= 1'b0;
    end else begin
      result_valid <= fill_do || emit_status;
      if (clr_found) begin
        valid[found_idx] <= 1'b0;
      end
      if (fill_do && (best.remaining == q)) begin
        valid[best_idx] <= 1'b0;
      end
      if (rest_do) begin
        valid[idx[SLOT_IW-1:0]] <= 1'b1;
        arrival_counter         <= arrival_counter + 32'd1;
      end
      if (sweep_begin) begin
        pv        <= 1'b0;
        have_best <= 1'b0;
      end else begin
        pv <= issue && ((state == S_FIND) || (state == S_SCAN));
        if (state == S_SCAN && cand && better) begin
          have_best <= 1'b1;
        end
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    st_code <= st_next;
    pidx    <= idx[SLOT_IW-1:0];
    if (sweep_begin) begin
      idx <= '0;
    end else if (issue) begin
      idx <= idx + SLOT_CW'(1);
    end

    if (state == S_IDLE && start) begin
      r_kind  <= kind;
      r_id    <= order_id;
      r_side  <= side;
      r_typ   <= order_type;
      r_price <= price;
      r_rem   <= quantity;
      r_ts    <= sequence_req;
      r_sym   <= symbol;
      found   <= 1'b0;
    end

    if (state == S_FIND && id_match) begin
      found      <= 1'b1;
      found_idx  <= pidx;
      found_side <= rd_entry.side;
      found_sym  <= rd_entry.symbol;
    end

    // modify re-enters as a limit order on the resting side and symbol
    if (take_found) begin
      r_side <= found_side;
      r_sym  <= found_sym;
      r_typ  <= TYP_LIMIT;
    end

    if (state == S_SCAN && cand && better) begin
      best     <= rd_entry;
      best_idx <= pidx;
      best_age <= age;
    end

    if (fill_do) begin
      r_rem         <= rem_after;
      result_kind   <= RK_FILL;
      buy_order_id  <= (r_side == SIDE_BUY) ? r_id : best.order_id;
      sell_order_id <= (r_side == SIDE_BUY) ? best.order_id : r_id;
      fill_price    <= best.price;
      fill_quantity <= q;
      timestamp     <= r_ts;
      fill_symbol   <= r_sym;
      status        <= ST_DONE;
      last          <= 1'b0;
    end else if (emit_status) begin
      result_kind   <= RK_STATUS;
      buy_order_id  <= 32'd0;
      sell_order_id <= 32'd0;
      fill_price    <= 32'd0;
      fill_quantity <= 32'd0;
      timestamp     <= 32'd0;
      fill_symbol   <= 32'd0;
      status        <= st_code;
      last          <= 1'b1;
    end
  end

  // run ends exactly with the status result
  a_end_with_status: assert property (@(posedge clk) disable iff (rst)
    $fell(busy) |-> (result_valid && last))
    else $error("busy dropped without a final status");

  // nothing is reported in the cycle after a request is taken
  a_accept_quiet: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> (busy && !result_valid))
    else $error("result right after accept");

  // a fill never closes the run
  a_fill_busy: assert property (@(posedge clk) disable iff (rst)
    (result_valid && !last) |-> (busy && result_kind == RK_FILL))
    else $error("fill outside a run");

endmodule
